@@ rtl/core/tdr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tdr_pkg;

    localparam int DIVIDER_WIDTH_DEFAULT = 16;
    localparam int DIV_COUNT_W = 16;
    localparam int TICK_W = 8;
    localparam int TIMER_W = 8;
    localparam int CTL_W = 3;
    localparam int CTL_ENABLE_BIT = 2;
    localparam int SEL_W = 4;

    localparam logic [1:0] RATE_SLOW = 2'd0;
    localparam logic [1:0] RATE_FAST = 2'd1;
    localparam logic [1:0] RATE_MID_FAST = 2'd2;
    localparam logic [1:0] RATE_MID_SLOW = 2'd3;

    localparam logic [SEL_W-1:0] TAP_SLOW = 4'd9;
    localparam logic [SEL_W-1:0] TAP_FAST = 4'd3;
    localparam logic [SEL_W-1:0] TAP_MID_FAST = 4'd5;
    localparam logic [SEL_W-1:0] TAP_MID_SLOW = 4'd7;

    localparam logic FUNC_ADVANCE = 1'b0;
    localparam logic FUNC_CONTROL = 1'b1;

    typedef struct packed {
        logic                func;
        logic [TICK_W-1:0]   tick_cycles;
        logic [CTL_W-1:0]    control_value;
    } in_req_t;

    typedef struct packed {
        logic [DIV_COUNT_W-1:0] divider_count;
        logic [TIMER_W-1:0]     timer_count;
        logic [TIMER_W-1:0]     overflow_count;
        logic                   interrupt_pending;
    } out_req_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_START,
        OP_TICK,
        OP_ADD,
        OP_CTRL
    } step_op_t;

    typedef struct packed {
        step_op_t            op;
        logic [TICK_W-1:0]   ticks;
        logic [CTL_W-1:0]    ctl;
    } step_cmd_t;

    typedef struct packed {
        logic                enabled;
        logic                irq;
        logic [TIMER_W-1:0]  timer;
        logic [TIMER_W-1:0]  wraps;
    } step_status_t;

    function automatic logic [SEL_W-1:0] sel_bit(input logic [1:0] rate);
        logic [SEL_W-1:0] tap;
        case (rate)
            RATE_FAST:     tap = TAP_FAST;
            RATE_MID_FAST: tap = TAP_MID_FAST;
            RATE_MID_SLOW: tap = TAP_MID_SLOW;
            default:       tap = TAP_SLOW;
        endcase
        return tap;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/tdr_step_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tdr_step_unit #(
    parameter int DIVIDER_WIDTH = tdr_pkg::DIVIDER_WIDTH_DEFAULT
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          reload_we,
    input  wire  [tdr_pkg::TIMER_W-1:0]  reload_data,
    input  tdr_pkg::step_cmd_t           cmd,
    output tdr_pkg::step_status_t        status,
    output logic [DIVIDER_WIDTH-1:0]     divider
);
    import tdr_pkg::*;

    logic [DIVIDER_WIDTH-1:0] divider_reg;
    logic [DIVIDER_WIDTH-1:0] divider_next;
    logic [TIMER_W-1:0]       timer_reg;
    logic [TIMER_W-1:0]       timer_next;
    logic [CTL_W-1:0]         control_reg;
    logic [CTL_W-1:0]         control_next;
    logic                     irq_reg;
    logic                     irq_next;
    logic [TIMER_W-1:0]       wraps_reg;
    logic [TIMER_W-1:0]       wraps_next;
    logic [TIMER_W-1:0]       reload_reg;

    logic [SEL_W-1:0]         sel_cur;
    logic [SEL_W-1:0]         sel_new;
    logic [DIVIDER_WIDTH-1:0] div_inc;
    logic [TIMER_W:0]         timer_inc;
    logic                     tick_fall;
    logic                     glitch;
    logic                     bump;
    logic                     wrap;

    always_comb
    begin
        sel_cur   = sel_bit(control_reg[1:0]);
        sel_new   = sel_bit(cmd.ctl[1:0]);
        div_inc   = divider_reg + DIVIDER_WIDTH'(1);
        timer_inc = {1'b0, timer_reg} + (TIMER_W+1)'(1);
        tick_fall = divider_reg[sel_cur] & ~div_inc[sel_cur];
        glitch    = (control_reg[CTL_ENABLE_BIT] & divider_reg[sel_cur])
                  & ~(cmd.ctl[CTL_ENABLE_BIT] & divider_reg[sel_new]);
        bump      = ((cmd.op == OP_TICK) & tick_fall) | ((cmd.op == OP_CTRL) & glitch);
        wrap      = bump & timer_inc[TIMER_W];

        divider_next = divider_reg;
        control_next = control_reg;
        wraps_next   = wraps_reg;
        case (cmd.op)
            OP_START: wraps_next = '0;
            OP_TICK:
            begin
                divider_next = div_inc;
                wraps_next   = wraps_reg + TIMER_W'(wrap);
            end
            OP_ADD:
            begin
                divider_next = divider_reg + DIVIDER_WIDTH'(cmd.ticks);
                wraps_next   = '0;
            end
            OP_CTRL:
            begin
                control_next = cmd.ctl;
                wraps_next   = TIMER_W'(wrap);
            end
            default: ;
        endcase

        timer_next = timer_reg;
        irq_next   = irq_reg;
        if (bump)
        begin
            if (wrap)
            begin
                timer_next = reload_reg;
                irq_next   = 1'b1;
            end
            else
            begin
                timer_next = timer_inc[TIMER_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divider_reg <= '0;
            timer_reg   <= '0;
            control_reg <= '0;
            irq_reg     <= 1'b0;
            wraps_reg   <= '0;
            reload_reg  <= '0;
        end
        else
        begin
            divider_reg <= divider_next;
            timer_reg   <= timer_next;
            control_reg <= control_next;
            irq_reg     <= irq_next;
            wraps_reg   <= wraps_next;
            if (reload_we)
            begin
                reload_reg <= reload_data;
            end
        end
    end

    assign divider        = divider_reg;
    assign status.enabled = control_reg[CTL_ENABLE_BIT];
    assign status.irq     = irq_reg;
    assign status.timer   = timer_reg;
    assign status.wraps   = wraps_reg;

endmodule

`default_nettype wire

@@ rtl/core/divider_timer_with_reload.sv @@
// Divider and timer with reload.
// Input channel (in_valid, in_stall, in_req): each request either advances the
// divider by tick_cycles clocks or writes the three-bit timer control.
// Output channel (out_valid, out_stall, out_req): exactly one result per request,
// carrying the divider, timer, wrap count of that request and the sticky interrupt.
// The reload value must be written with reload_we and reload_data only while the
// block is idle; the block itself does not enforce this. A control write, or an
// advance while the timer is disabled, finishes in one step applied at acceptance;
// its result is then loaded into the output register from ST_RUN.
// An advance with the timer enabled walks the divider one tick per clock through
// a single incrementer and edge detector; its result is loaded after the last tick.
// The input is stalled from acceptance until the result is loaded into the
// output register; one request is handled at a time.
// A result waiting under out_stall does not block the next request, but a
// finished request is held until the output register is free.
// Reset clears the divider, timer, control, interrupt flag and reload value,
// drops out_valid and leaves in_stall low.
`timescale 1ns / 1ps
`default_nettype none

module divider_timer_with_reload #(
    parameter int DIVIDER_WIDTH = tdr_pkg::DIVIDER_WIDTH_DEFAULT
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_stall,
    input  tdr_pkg::in_req_t             in_req,
    output logic                         out_valid,
    input  wire                          out_stall,
    output tdr_pkg::out_req_t            out_req,
    input  wire                          reload_we,
    input  wire  [tdr_pkg::TIMER_W-1:0]  reload_data
);
    import tdr_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t                   state_reg;
    state_t                   state_next;
    logic [TICK_W-1:0]        ticks_left_reg;
    logic [TICK_W-1:0]        ticks_left_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    out_req_t                 out_req_reg;
    out_req_t                 out_req_next;

    step_cmd_t                cmd;
    step_status_t             status;
    logic [DIVIDER_WIDTH-1:0] divider;
    logic                     accept;
    logic                     finish;

    tdr_step_unit #(
        .DIVIDER_WIDTH (DIVIDER_WIDTH)
    ) u_step (
        .clk         (clk),
        .rst_n       (rst_n),
        .reload_we   (reload_we),
        .reload_data (reload_data),
        .cmd         (cmd),
        .status      (status),
        .divider     (divider)
    );

    always_comb
    begin
        accept = (state_reg == ST_IDLE) && in_valid;
        finish = (state_reg == ST_RUN) && (ticks_left_reg == '0)
              && (!out_valid_reg || !out_stall);

        cmd.op          = OP_NONE;
        cmd.ticks       = in_req.tick_cycles;
        cmd.ctl         = in_req.control_value;
        state_next      = state_reg;
        ticks_left_next = ticks_left_reg;
        out_req_next    = out_req_reg;
        out_valid_next  = out_valid_reg && out_stall;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next      = ST_RUN;
                    ticks_left_next = '0;
                    if (in_req.func == FUNC_CONTROL)
                    begin
                        cmd.op = OP_CTRL;
                    end
                    else if (status.enabled)
                    begin
                        cmd.op          = OP_START;
                        ticks_left_next = in_req.tick_cycles;
                    end
                    else
                    begin
                        cmd.op = OP_ADD;
                    end
                end
            end
            ST_RUN:
            begin
                if (ticks_left_reg != '0)
                begin
                    cmd.op          = OP_TICK;
                    ticks_left_next = ticks_left_reg - TICK_W'(1);
                end
                else if (finish)
                begin
                    state_next                     = ST_IDLE;
                    out_valid_next                 = 1'b1;
                    out_req_next.divider_count     = DIV_COUNT_W'(divider);
                    out_req_next.timer_count       = status.timer;
                    out_req_next.overflow_count    = status.wraps;
                    out_req_next.interrupt_pending = status.irq;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ticks_left_reg <= '0;
            out_valid_reg  <= 1'b0;
            out_req_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            ticks_left_reg <= ticks_left_next;
            out_valid_reg  <= out_valid_next;
            out_req_reg    <= out_req_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_req   = out_req_reg;

`ifndef SYNTHESIS
    a_wraps_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_req.overflow_count <= 8'd16))
        else $error("more timer wraps in one request than the divider allows");

    a_wrap_sets_irq: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_req.overflow_count != '0)) |-> out_req.interrupt_pending)
        else $error("timer wrapped without interrupt flag");

    a_irq_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(status.irq))
        else $error("interrupt flag cleared without reset");

    a_idle_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> (!in_stall && out_valid))
        else $error("finished request did not reach the output register");
`endif

endmodule

`default_nettype wire

@@ tb/tb_divider_timer_with_reload.sv @@
`timescale 1ns / 1ps

module tb_divider_timer_with_reload;
    import tdr_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int GAP_MAX = 11;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_req_t in_req = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_req_t out_req;
    logic reload_we = 1'b0;
    logic [TIMER_W-1:0] reload_data = '0;

    logic [DIV_COUNT_W-1:0] div_model = '0;
    logic [TIMER_W-1:0] timer_model = '0;
    logic [TIMER_W-1:0] reload_model = '0;
    logic [CTL_W-1:0] ctl_model = '0;
    logic irq_model = 1'b0;

    out_req_t pending_results[$];
    out_req_t oldest;

    int errors = 0;
    int n_requests = 0;
    int n_ctl_writes = 0;
    int n_results = 0;
    int n_wraps = 0;
    int n_div_wraps = 0;
    int send_gap_max = GAP_MAX;
    bit receiver_quiet = 1'b0;
    int hold_len = 0;
    int idle_cycles = 0;

    divider_timer_with_reload u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_req      (in_req),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_req     (out_req),
        .reload_we   (reload_we),
        .reload_data (reload_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [SEL_W-1:0] tap_of(input logic [1:0] rate);
        case (rate)
            RATE_FAST:     return TAP_FAST;
            RATE_MID_FAST: return TAP_MID_FAST;
            RATE_MID_SLOW: return TAP_MID_SLOW;
            default:       return TAP_SLOW;
        endcase
    endfunction

    function automatic logic bump_timer_model();
        timer_model = timer_model + TIMER_W'(1);
        if (timer_model == '0)
        begin
            timer_model = reload_model;
            irq_model = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic step_timer_model(input in_req_t req, output out_req_t res);
        logic [SEL_W-1:0] tap;
        logic was_high;
        logic carry;
        logic old_in;
        logic new_in;
        logic [TIMER_W-1:0] wraps;
        wraps = '0;
        if (req.func == FUNC_ADVANCE)
        begin
            if (!ctl_model[CTL_ENABLE_BIT])
            begin
                {carry, div_model} = {1'b0, div_model}
                                     + (DIV_COUNT_W+1)'(req.tick_cycles);
                n_div_wraps += int'(carry);
            end
            else
            begin
                tap = tap_of(ctl_model[1:0]);
                for (int i = 0; i < int'(req.tick_cycles); i++)
                begin
                    was_high = div_model[tap];
                    div_model = div_model + DIV_COUNT_W'(1);
                    if (div_model == '0)
                        n_div_wraps++;
                    if (was_high && !div_model[tap])
                        wraps = wraps + TIMER_W'(bump_timer_model());
                end
            end
        end
        else
        begin
            old_in = ctl_model[CTL_ENABLE_BIT] & div_model[tap_of(ctl_model[1:0])];
            new_in = req.control_value[CTL_ENABLE_BIT]
                     & div_model[tap_of(req.control_value[1:0])];
            if (old_in && !new_in)
                wraps = wraps + TIMER_W'(bump_timer_model());
            ctl_model = req.control_value;
            n_ctl_writes++;
        end
        res.divider_count = div_model;
        res.timer_count = timer_model;
        res.overflow_count = wraps;
        res.interrupt_pending = irq_model;
    endtask

    function automatic in_req_t adv_req(input logic [TICK_W-1:0] ticks);
        in_req_t r;
        r.func = FUNC_ADVANCE;
        r.tick_cycles = ticks;
        r.control_value = CTL_W'($urandom_range(0, 7));
        return r;
    endfunction

    function automatic in_req_t ctl_req(input logic en, input logic [1:0] rate);
        in_req_t r;
        r.func = FUNC_CONTROL;
        r.tick_cycles = TICK_W'($urandom_range(0, 255));
        r.control_value = {en, rate};
        return r;
    endfunction

    task automatic send_request(input in_req_t req);
        int gap;
        out_req_t res;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req <= req;
        do @(posedge clk); while (in_stall);
        step_timer_model(req, res);
        pending_results.push_back(res);
        n_requests++;
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reload(input logic [TIMER_W-1:0] value);
        reload_we <= 1'b1;
        reload_data <= value;
        @(posedge clk);
        reload_we <= 1'b0;
        reload_model = value;
    endtask

    task automatic test_directed_cases();
        send_request(adv_req(8'd0));
        send_request(adv_req(8'd255));
        send_request(ctl_req(1'b1, RATE_MID_SLOW));
        send_request(ctl_req(1'b1, RATE_SLOW));
        send_request(ctl_req(1'b1, RATE_FAST));
        send_request(adv_req(8'd255));
        send_request(ctl_req(1'b0, RATE_FAST));
        send_request(ctl_req(1'b0, RATE_SLOW));
        send_request(ctl_req(1'b0, RATE_MID_FAST));
        send_request(ctl_req(1'b0, RATE_MID_SLOW));
        send_request(ctl_req(1'b1, RATE_MID_FAST));
        send_request(adv_req(8'd1));
        send_request(adv_req(8'd128));
        wait_for_drain();
    endtask

    task automatic test_reload_wrap();
        write_reload(8'hFF);
        send_request(ctl_req(1'b1, RATE_FAST));
        repeat (18) send_request(adv_req(8'd255));
        wait_for_drain();
    endtask

    task automatic test_divider_wrap();
        write_reload(8'h80);
        send_request(ctl_req(1'b1, RATE_SLOW));
        repeat (260) send_request(adv_req(8'd255));
        wait_for_drain();
    endtask

    task automatic test_backpressure();
        hold_len = 120;
        send_gap_max = 0;
        repeat (15)
        begin
            send_request(adv_req(TICK_W'($urandom_range(0, 12))));
            send_request(ctl_req(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3))));
        end
        send_gap_max = GAP_MAX;
        wait_for_drain();
    endtask

    task automatic test_random_mix();
        int pick;
        logic [TIMER_W-1:0] value;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       value = 8'h00;
                1:       value = 8'hFF;
                default: value = TIMER_W'($urandom_range(0, 255));
            endcase
            write_reload(value);
            receiver_quiet = (phase == 2);
            send_gap_max = (phase == 2) ? 0 : GAP_MAX;
            repeat (130)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 20)
                    send_request(ctl_req($urandom_range(0, 3) != 0,
                                         2'($urandom_range(0, 3))));
                else if (pick < 30)
                    send_request(adv_req(TICK_W'($urandom_range(0, 255))));
                else
                    send_request(adv_req(TICK_W'($urandom_range(4, 24))));
            end
            wait_for_drain();
        end
        receiver_quiet = 1'b0;
        send_gap_max = GAP_MAX;
    endtask

    always
    begin : result_sink
        int stall_len;
        if (hold_len > 0)
        begin
            stall_len = hold_len;
            hold_len = 0;
        end
        else if (receiver_quiet)
            stall_len = 0;
        else
            stall_len = $urandom_range(0, GAP_MAX);
        if (stall_len > 0)
        begin
            out_stall <= 1'b1;
            repeat (stall_len) @(posedge clk);
        end
        out_stall <= 1'b0;
        do @(posedge clk); while (!(rst_n && out_valid && !out_stall));
    end

    function automatic void check_field(input string name, input int unsigned want_v,
                                        input int unsigned got_v);
        if (want_v != got_v)
        begin
            errors++;
            $display("%0t: %s expected %0d got %0d", $time, name, want_v, got_v);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            n_results++;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing expected, expected none got %h",
                         $time, out_req);
            end
            else
            begin
                oldest = pending_results.pop_front();
                check_field("divider_count", 32'(oldest.divider_count),
                            32'(out_req.divider_count));
                check_field("timer_count", 32'(oldest.timer_count),
                            32'(out_req.timer_count));
                check_field("overflow_count", 32'(oldest.overflow_count),
                            32'(out_req.overflow_count));
                check_field("interrupt_pending", 32'(oldest.interrupt_pending),
                            32'(out_req.interrupt_pending));
                n_wraps += int'(out_req.overflow_count);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_reload_wrap();
        test_divider_wrap();
        test_backpressure();
        test_random_mix();
        wait_for_drain();
        repeat (10) @(posedge clk);
        $display("Checked %0d results for %0d requests, %0d of them control writes.",
                 n_results, n_requests, n_ctl_writes);
        $display("The timer wrapped %0d times and the divider %0d times, reloads 0x00 to 0xFF.",
                 n_wraps, n_div_wraps);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
